// ===== rtl/esv_pkg.sv =====
package esv_pkg;

  localparam int unsigned MOD_WIDTH = 31;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY   = 2'd2;

  // reset values of generator and key (prime resets to all ones)
  localparam int unsigned GEN_RESET = 7;
  localparam int unsigned KEY_RESET = 1;

  typedef enum logic {
    ALU_DIV,
    ALU_MULMOD
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

// ===== rtl/esv_alu.sv =====
// bit-serial shared unit: restoring divide or interleaved modular multiply
module esv_alu #(
  parameter int unsigned MOD_WIDTH = esv_pkg::MOD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  esv_pkg::alu_req_t    req_i,
  input  logic [MOD_WIDTH-1:0] a_i,
  input  logic [MOD_WIDTH-1:0] b_i,
  input  logic [MOD_WIDTH-1:0] n_i,
  output esv_pkg::alu_stat_t   stat_o,
  output logic [MOD_WIDTH-1:0] res_o,
  output logic [MOD_WIDTH-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(MOD_WIDTH);

  logic                 active_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  esv_pkg::alu_op_e     op_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] sh_q;
  logic [MOD_WIDTH-1:0] quo_q;
  logic [MOD_WIDTH-1:0] opa_q;
  logic [MOD_WIDTH-1:0] n_q;

  logic                 is_mul;
  logic [MOD_WIDTH:0]   dbl;
  logic                 qbit;
  logic [MOD_WIDTH:0]   red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   red2;
  logic [MOD_WIDTH-1:0] acc_d;

  always_comb begin
    is_mul = (op_q == esv_pkg::ALU_MULMOD);
    dbl    = is_mul ? {acc_q, 1'b0} : {acc_q, sh_q[MOD_WIDTH-1]};
    qbit   = (dbl >= {1'b0, n_q});
    red    = qbit ? (dbl - {1'b0, n_q}) : dbl;
    sum    = red + ((is_mul && sh_q[MOD_WIDTH-1]) ? {1'b0, opa_q} : '0);
    red2   = (sum >= {1'b0, n_q}) ? (sum - {1'b0, n_q}) : sum;
    acc_d  = is_mul ? red2[MOD_WIDTH-1:0] : red[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      op_q     <= esv_pkg::ALU_DIV;
    end else begin
      done_q <= active_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= CntW'(MOD_WIDTH - 1);
        op_q     <= req_i.op;
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      quo_q <= '0;
      if (req_i.op == esv_pkg::ALU_MULMOD) begin
        opa_q <= a_i;
        sh_q  <= b_i;
        n_q   <= n_i;
      end else begin
        opa_q <= '0;
        sh_q  <= a_i;
        n_q   <= b_i;
      end
    end else if (active_q) begin
      acc_q <= acc_d;
      sh_q  <= {sh_q[MOD_WIDTH-2:0], 1'b0};
      quo_q <= {quo_q[MOD_WIDTH-2:0], qbit};
    end
  end

  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;
  assign res_o       = acc_q;
  assign quo_o       = quo_q;

endmodule

// ===== rtl/elgamal_sign_verify_engine.sv =====
// the nonce search takes up to about 45 gcd steps per candidate; then come five modular
// exponentiations and an extended euclid of up to about 45 steps, all run on the one
// bit-serial shared unit
// throughput: one request at a time; the next is taken once the sequencer is idle
// reset: prime = all ones, generator = 7, key = 1, no result pending
module elgamal_sign_verify_engine #(
  parameter int unsigned MOD_WIDTH = esv_pkg::MOD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [esv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MOD_WIDTH-1:0]          cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [MOD_WIDTH-1:0]          message_value_i,
  input  logic [MOD_WIDTH-1:0]          nonce_start_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic [MOD_WIDTH-1:0]          nonce_used_o,
  output logic [MOD_WIDTH-1:0]          public_key_o,
  output logic [MOD_WIDTH-1:0]          sig_r_o,
  output logic [MOD_WIDTH-1:0]          sig_s_o,
  output logic [MOD_WIDTH-1:0]          check_left_o,
  output logic [MOD_WIDTH-1:0]          check_right_o,
  output logic                          sig_valid_o
);

  localparam int unsigned W = MOD_WIDTH;

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_NCHK    = 5'd1;
  localparam logic [4:0] ST_GCD     = 5'd2;
  localparam logic [4:0] ST_GCD_W   = 5'd3;
  localparam logic [4:0] ST_GRED    = 5'd4;
  localparam logic [4:0] ST_GRED_W  = 5'd5;
  localparam logic [4:0] ST_POW     = 5'd6;
  localparam logic [4:0] ST_POW_MW  = 5'd7;
  localparam logic [4:0] ST_POW_SQ  = 5'd8;
  localparam logic [4:0] ST_POW_SW  = 5'd9;
  localparam logic [4:0] ST_POWRET  = 5'd10;
  localparam logic [4:0] ST_EUC     = 5'd11;
  localparam logic [4:0] ST_EUC_DW  = 5'd12;
  localparam logic [4:0] ST_EUC_M   = 5'd13;
  localparam logic [4:0] ST_EUC_MW  = 5'd14;
  localparam logic [4:0] ST_XRED    = 5'd15;
  localparam logic [4:0] ST_XRED_W  = 5'd16;
  localparam logic [4:0] ST_XR      = 5'd17;
  localparam logic [4:0] ST_XR_W    = 5'd18;
  localparam logic [4:0] ST_MRED    = 5'd19;
  localparam logic [4:0] ST_MRED_W  = 5'd20;
  localparam logic [4:0] ST_SIG     = 5'd21;
  localparam logic [4:0] ST_SIG_W   = 5'd22;
  localparam logic [4:0] ST_FIN     = 5'd23;
  localparam logic [4:0] ST_FIN_W   = 5'd24;
  localparam logic [4:0] ST_OUT     = 5'd25;

  // which exponentiation is running
  localparam logic [2:0] PH_Y    = 3'd0;
  localparam logic [2:0] PH_R    = 3'd1;
  localparam logic [2:0] PH_LEFT = 3'd2;
  localparam logic [2:0] PH_YR   = 3'd3;
  localparam logic [2:0] PH_RS   = 3'd4;

  // configuration registers
  logic [W-1:0] p_q, g_q, x_q;

  logic [4:0]   state_q;
  logic [2:0]   phase_q;
  logic         fail_q;

  // working registers
  logic [W-1:0] msg_q, k_q, m_q;
  logic [W-1:0] ga_q, gb_q;       // gcd pair, later quotient / x mod m / x*r / diff
  logic [W-1:0] gr_q, y_q, r_q, s_q, kinv_q, left_q, a1_q;
  logic [W-1:0] base_q, exp_q, acc_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q;

  // result register
  logic         out_valid_q;
  logic         status_q, sig_valid_q;
  logic [W-1:0] nonce_q, pub_q, sr_q, ss_q, cl_q, cr_q;

  // shared unit
  esv_pkg::alu_req_t  alu_req;
  esv_pkg::alu_stat_t alu_stat;
  logic [W-1:0]       alu_a, alu_b, alu_n;
  logic [W-1:0]       alu_res, alu_quo;

  logic [W:0]         tnew;
  logic [W:0]         dnew;
  logic               out_free;

  esv_alu #(
    .MOD_WIDTH(W)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .n_i    (alu_n),
    .stat_o (alu_stat),
    .res_o  (alu_res),
    .quo_o  (alu_quo)
  );

  // operand selection and start per issuing state
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = esv_pkg::ALU_DIV;
    alu_a         = '0;
    alu_b         = '0;
    alu_n         = p_q;
    unique case (state_q)
      ST_GCD: begin
        alu_req.start = (gb_q != '0);
        alu_a         = ga_q;
        alu_b         = gb_q;
      end
      ST_GRED: begin
        alu_req.start = 1'b1;
        alu_a         = g_q;
        alu_b         = p_q;
      end
      ST_POW: begin
        alu_req.start = (exp_q != '0) && exp_q[0];
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = acc_q;
        alu_b         = base_q;
      end
      ST_POW_SQ: begin
        alu_req.start = 1'b1;
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = base_q;
        alu_b         = base_q;
      end
      ST_EUC: begin
        alu_req.start = (r1_q != '0);
        alu_a         = r0_q;
        alu_b         = r1_q;
      end
      ST_EUC_M: begin
        alu_req.start = 1'b1;
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = ga_q;
        alu_b         = t1_q;
        alu_n         = m_q;
      end
      ST_XRED: begin
        alu_req.start = 1'b1;
        alu_a         = x_q;
        alu_b         = m_q;
      end
      ST_XR: begin
        alu_req.start = 1'b1;
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = ga_q;
        alu_b         = r_q;
        alu_n         = m_q;
      end
      ST_MRED: begin
        alu_req.start = 1'b1;
        alu_a         = msg_q;
        alu_b         = m_q;
      end
      ST_SIG: begin
        alu_req.start = 1'b1;
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = kinv_q;
        alu_b         = gb_q;
        alu_n         = m_q;
      end
      ST_FIN: begin
        alu_req.start = 1'b1;
        alu_req.op    = esv_pkg::ALU_MULMOD;
        alu_a         = a1_q;
        alu_b         = acc_q;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  // euclid coefficient step t0 - q*t1 mod m, and message minus x*r mod m
  always_comb begin
    tnew = (t0_q >= alu_res) ? ({1'b0, t0_q} - {1'b0, alu_res})
                             : ({1'b0, t0_q} + {1'b0, m_q} - {1'b0, alu_res});
    dnew = (alu_res >= gb_q) ? ({1'b0, alu_res} - {1'b0, gb_q})
                             : ({1'b0, alu_res} + {1'b0, m_q} - {1'b0, gb_q});
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '1;
      g_q <= W'(esv_pkg::GEN_RESET);
      x_q <= W'(esv_pkg::KEY_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esv_pkg::CFG_PRIME: p_q <= cfg_data_i;
        esv_pkg::CFG_GEN:   g_q <= cfg_data_i;
        esv_pkg::CFG_KEY:   x_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_Y;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result in the same cycle keeps valid high
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            fail_q  <= (p_q < W'(3));
            state_q <= (p_q < W'(3)) ? ST_OUT : ST_NCHK;
          end
        end
        ST_NCHK: begin
          if (k_q > m_q - 1'b1) begin
            fail_q  <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (gb_q == '0) begin
            state_q <= (ga_q == W'(1)) ? ST_GRED : ST_NCHK;
          end else begin
            state_q <= ST_GCD_W;
          end
        end
        ST_GCD_W:  if (alu_stat.done) state_q <= ST_GCD;
        ST_GRED:   state_q <= ST_GRED_W;
        ST_GRED_W: begin
          if (alu_stat.done) begin
            phase_q <= PH_Y;
            state_q <= ST_POW;
          end
        end
        ST_POW: begin
          if (exp_q == '0) begin
            state_q <= ST_POWRET;
          end else begin
            state_q <= exp_q[0] ? ST_POW_MW : ST_POW_SQ;
          end
        end
        ST_POW_MW: if (alu_stat.done) state_q <= ST_POW_SQ;
        ST_POW_SQ: state_q <= ST_POW_SW;
        ST_POW_SW: if (alu_stat.done) state_q <= ST_POW;
        ST_POWRET: begin
          unique case (phase_q)
            PH_Y: begin
              phase_q <= PH_R;
              state_q <= ST_POW;
            end
            PH_R:    state_q <= ST_EUC;
            PH_LEFT: begin
              phase_q <= PH_YR;
              state_q <= ST_POW;
            end
            PH_YR: begin
              phase_q <= PH_RS;
              state_q <= ST_POW;
            end
            default: state_q <= ST_FIN;
          endcase
        end
        ST_EUC:    state_q <= (r1_q == '0) ? ST_XRED : ST_EUC_DW;
        ST_EUC_DW: if (alu_stat.done) state_q <= ST_EUC_M;
        ST_EUC_M:  state_q <= ST_EUC_MW;
        ST_EUC_MW: if (alu_stat.done) state_q <= ST_EUC;
        ST_XRED:   state_q <= ST_XRED_W;
        ST_XRED_W: if (alu_stat.done) state_q <= ST_XR;
        ST_XR:     state_q <= ST_XR_W;
        ST_XR_W:   if (alu_stat.done) state_q <= ST_MRED;
        ST_MRED:   state_q <= ST_MRED_W;
        ST_MRED_W: if (alu_stat.done) state_q <= ST_SIG;
        ST_SIG:    state_q <= ST_SIG_W;
        ST_SIG_W: begin
          if (alu_stat.done) begin
            phase_q <= PH_LEFT;
            state_q <= ST_POW;
          end
        end
        ST_FIN:    state_q <= ST_FIN_W;
        ST_FIN_W:  if (alu_stat.done) state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          msg_q <= message_value_i;
          k_q   <= nonce_start_i;
          m_q   <= p_q - 1'b1;
        end
      end
      ST_NCHK: begin
        ga_q <= k_q;
        gb_q <= m_q;
      end
      ST_GCD: begin
        if (gb_q == '0 && ga_q != W'(1)) begin
          k_q <= k_q + 1'b1;
        end
      end
      ST_GCD_W: begin
        if (alu_stat.done) begin
          ga_q <= gb_q;
          gb_q <= alu_res;
        end
      end
      ST_GRED_W: begin
        if (alu_stat.done) begin
          gr_q   <= alu_res;
          base_q <= alu_res;
          exp_q  <= x_q;
          acc_q  <= W'(1);
        end
      end
      ST_POW_MW: if (alu_stat.done) acc_q <= alu_res;
      ST_POW_SW: begin
        if (alu_stat.done) begin
          base_q <= alu_res;
          exp_q  <= exp_q >> 1;
        end
      end
      ST_POWRET: begin
        unique case (phase_q)
          PH_Y: begin
            y_q    <= acc_q;
            base_q <= gr_q;
            exp_q  <= k_q;
            acc_q  <= W'(1);
          end
          PH_R: begin
            r_q  <= acc_q;
            r0_q <= m_q;
            r1_q <= k_q;
            t0_q <= '0;
            t1_q <= W'(1);
          end
          PH_LEFT: begin
            left_q <= acc_q;
            base_q <= y_q;
            exp_q  <= r_q;
            acc_q  <= W'(1);
          end
          PH_YR: begin
            a1_q   <= acc_q;
            base_q <= r_q;
            exp_q  <= s_q;
            acc_q  <= W'(1);
          end
          default: ;
        endcase
      end
      ST_EUC: if (r1_q == '0) kinv_q <= t0_q;
      ST_EUC_DW: begin
        if (alu_stat.done) begin
          // a quotient equal to m reduces to zero
          ga_q <= (alu_quo == m_q) ? '0 : alu_quo;
          r0_q <= r1_q;
          r1_q <= alu_res;
        end
      end
      ST_EUC_MW: begin
        if (alu_stat.done) begin
          t0_q <= t1_q;
          t1_q <= tnew[W-1:0];
        end
      end
      ST_XRED_W: if (alu_stat.done) ga_q <= alu_res;
      ST_XR_W:   if (alu_stat.done) gb_q <= alu_res;
      ST_MRED_W: if (alu_stat.done) gb_q <= dnew[W-1:0];
      ST_SIG_W: begin
        if (alu_stat.done) begin
          s_q    <= alu_res;
          base_q <= gr_q;
          exp_q  <= msg_q;
          acc_q  <= W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register, loaded when the previous result has been taken
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      status_q <= fail_q;
      if (fail_q) begin
        nonce_q     <= '0;
        pub_q       <= '0;
        sr_q        <= '0;
        ss_q        <= '0;
        cl_q        <= '0;
        cr_q        <= '0;
        sig_valid_q <= 1'b0;
      end else begin
        nonce_q     <= k_q;
        pub_q       <= y_q;
        sr_q        <= r_q;
        ss_q        <= s_q;
        cl_q        <= left_q;
        cr_q        <= alu_res;
        sig_valid_q <= (left_q == alu_res);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign nonce_used_o  = nonce_q;
  assign public_key_o  = pub_q;
  assign sig_r_o       = sr_q;
  assign sig_s_o       = ss_q;
  assign check_left_o  = cl_q;
  assign check_right_o = cr_q;
  assign sig_valid_o   = sig_valid_q;

  // the shared unit is only started once its previous operation has finished
  a_alu_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_stat.busy)
    else $error("shared unit started while busy");

  // a failed request carries zero in nonce, r and s and a clear valid flag
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (nonce_used_o == '0 && sig_s_o == '0 &&
                                   sig_r_o == '0 && !sig_valid_o))
    else $error("failed result with nonzero fields");

  // the valid flag agrees with both verification sides
  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (sig_valid_o == (check_left_o == check_right_o)))
    else $error("signature flag disagrees with check values");

endmodule

// ===== dv/elgamal_sign_verify_engine_tb.sv =====
`default_nettype none

module elgamal_sign_verify_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = esv_pkg::MOD_WIDTH;
  localparam bit STAT_SIGNED   = 1'b0;
  localparam bit STAT_NO_NONCE = 1'b1;
  // cycles with no handshake on either side before giving up
  localparam int unsigned STUCK_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 30000;

  typedef struct {
    bit         status;
    bit [W-1:0] nonce;
    bit [W-1:0] pub_key;
    bit [W-1:0] r;
    bit [W-1:0] s;
    bit [W-1:0] left;
    bit [W-1:0] right;
    bit         ok;
  } signature_t;

  typedef struct {
    bit [W-1:0] msg;
    bit [W-1:0] nonce;
  } sign_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_we = 1'b0;
  logic [esv_pkg::CFG_IDX_W-1:0] cfg_idx = esv_pkg::CFG_PRIME;
  logic [W-1:0]                  cfg_data = '0;

  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] msg_in = '0;
  logic [W-1:0] nonce_in = '0;

  logic         out_valid;
  logic         out_stall = 1'b0;
  logic         status_out;
  logic [W-1:0] nonce_out, pub_out, r_out, s_out, left_out, right_out;
  logic         ok_out;

  elgamal_sign_verify_engine dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .message_value_i(msg_in),
    .nonce_start_i  (nonce_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status_out),
    .nonce_used_o   (nonce_out),
    .public_key_o   (pub_out),
    .sig_r_o        (r_out),
    .sig_s_o        (s_out),
    .check_left_o   (left_out),
    .check_right_o  (right_out),
    .sig_valid_o    (ok_out)
  );

  // shadow of the configuration registers
  longint unsigned prime_q = 64'd2147483647;
  longint unsigned gen_q   = esv_pkg::GEN_RESET;
  longint unsigned key_q   = esv_pkg::KEY_RESET;

  sign_req_t  pending_reqs[$];
  signature_t expected_sigs[$];
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                              longint unsigned md);
    longint unsigned acc;
    acc = 1;
    base = base % md;
    while (ex > 0) begin
      if (ex[0]) acc = (acc * base) % md;
      base = (base * base) % md;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // extended euclid, a coprime to md
  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned md);
    longint r0, r1, t0, t1, q, tmp;
    r0 = md;
    r1 = a;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (t0 < 0) t0 = t0 + longint'(md);
    return longint'(t0) % md;
  endfunction

  // sign a message and verify the signature under the current registers
  function automatic signature_t sign_and_check(bit [W-1:0] msg_bits, bit [W-1:0] start);
    signature_t res;
    longint unsigned p, m, k, msg, y, r, kinv, xr, diff, s, l, rt;
    res = '{default: 0};
    res.status = STAT_NO_NONCE;
    p = prime_q;
    msg = msg_bits;
    k = start;
    if (p < 3) return res;
    m = p - 1;
    while (k <= m - 1 && gcd64(k, m) != 1) k++;
    if (k > m - 1) return res;
    y = pow_mod(gen_q, key_q, p);
    r = pow_mod(gen_q, k, p);
    kinv = inv_mod(k, m);
    xr = ((key_q % m) * r) % m;
    diff = (msg % m + m - xr) % m;
    s = (kinv * diff) % m;
    l = pow_mod(gen_q, msg, p);
    rt = (pow_mod(y, r, p) * pow_mod(r, s, p)) % p;
    res.status = STAT_SIGNED;
    res.nonce = k[W-1:0];
    res.pub_key = y[W-1:0];
    res.r = r[W-1:0];
    res.s = s[W-1:0];
    res.left = l[W-1:0];
    res.right = rt[W-1:0];
    res.ok = (l == rt);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // request driver: a held request only moves on once accepted
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_sigs = {expected_sigs, sign_and_check(msg_in, nonce_in)};
    end
    if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        sign_req_t req;
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        msg_in <= req.msg;
        nonce_in <= req.nonce;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long back-pressure window, counted here so the sender keeps offering
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (expected_sigs.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        signature_t e;
        e = expected_sigs.pop_front();
        if (status_out !== e.status) report_mismatch("status", status_out, e.status);
        if (nonce_out !== e.nonce) report_mismatch("nonce_used", nonce_out, e.nonce);
        if (pub_out !== e.pub_key) report_mismatch("public_key", pub_out, e.pub_key);
        if (r_out !== e.r) report_mismatch("sig_r", r_out, e.r);
        if (s_out !== e.s) report_mismatch("sig_s", s_out, e.s);
        if (left_out !== e.left) report_mismatch("check_left", left_out, e.left);
        if (right_out !== e.right) report_mismatch("check_right", right_out, e.right);
        if (ok_out !== e.ok) report_mismatch("sig_valid", ok_out, e.ok);
      end
    end
    out_stall <= (hold_left > 1) || ($urandom_range(99) < rx_idle_pct);
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("elgamal_sign_verify_engine_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // write all three registers back to back, then drop the enable
  task automatic set_config(longint unsigned p, longint unsigned g, longint unsigned x);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= esv_pkg::CFG_PRIME;
    cfg_data <= p[W-1:0];
    @(posedge clk);
    cfg_idx <= esv_pkg::CFG_GEN;
    cfg_data <= g[W-1:0];
    @(posedge clk);
    cfg_idx <= esv_pkg::CFG_KEY;
    cfg_data <= x[W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    prime_q = p[W-1:0];
    gen_q = g[W-1:0];
    key_q = x[W-1:0];
  endtask

  // wait until every queued request has produced its signature
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_sigs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_req(longint unsigned msg, longint unsigned nonce);
    sign_req_t req;
    req.msg = msg[W-1:0];
    req.nonce = nonce[W-1:0];
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic queue_random(int unsigned n);
    longint unsigned nonce;
    repeat (n) begin
      case ($urandom_range(4))
        0: nonce = $urandom;
        1: nonce = prime_q - 3 + $urandom_range(3);
        default: nonce = $urandom_range(32'(prime_q - 2), 0);
      endcase
      queue_req($urandom, nonce);
    end
  endtask

  longint unsigned primes[8] = '{5, 7, 13, 257, 65521, 1000003, 2147483629, 2147483647};

  initial begin
    longint unsigned p, g, x;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: message and nonce extremes
    queue_req(0, 2);
    queue_req(64'h7fff_ffff, 0);
    queue_req(12345, 1);
    queue_req(64'h5555_5555, 2147483645); // last candidate below p-1
    queue_req(64'h2aaa_aaaa, 2147483646); // nothing left to search
    queue_req(7, 64'h7fff_ffff);
    drain();

    // generator and key at their top values
    set_config(2147483647, 2147483646, 2147483645);
    queue_req(64'h7fff_ffff, 64'h4000_0000);
    queue_req(1, 3);
    drain();

    // smallest prime, then degenerate moduli
    set_config(3, 2, 1);
    queue_req(5, 0);
    queue_req(2, 1);
    queue_req(0, 2);
    drain();
    set_config(2, 2, 1);
    queue_req(9, 1);
    drain();
    set_config(0, 0, 0);
    queue_req(9, 1);
    drain();
    set_config(1, 7, 1);
    queue_req(9, 1);
    drain();

    // out of range generator and key on a small prime
    set_config(11, 64'h7fff_fff0, 64'h7fff_ffff);
    queue_req(64'h7fff_ffff, 4);
    queue_req(3, 9);
    drain();

    // random phases: sender-light idling, receiver-light idling, then none
    for (int ph = 0; ph < 6; ph++) begin
      p = primes[$urandom_range(7)];
      g = ($urandom_range(3) == 0) ? ($urandom & 32'h7fff_ffff)
                                   : $urandom_range(32'(p - 1), 2);
      x = ($urandom_range(3) == 0) ? ($urandom & 32'h7fff_ffff)
                                   : $urandom_range(32'(p - 2), 1);
      set_config(p, g, x);
      tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 45 : 0;
      rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 7 : 0;
      if (ph == 2) hold_req = 1'b1;
      queue_random(25);
      if (ph == 1) begin
        // sender pause until every outstanding result is back
        while (pending_reqs.size() > 0 || in_valid || expected_sigs.size() > 0) @(posedge clk);
      end
      queue_random(25);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("elgamal_sign_verify_engine_tb passed");
    end else begin
      $display("elgamal_sign_verify_engine_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
